>>> src/cict_pkg.sv
package cict_pkg;

  localparam logic [2:0] MODE_OBSERVE = 3'd0;
  localparam logic [2:0] MODE_TICK    = 3'd1;
  localparam logic [2:0] MODE_START   = 3'd2;
  localparam logic [2:0] MODE_CANCEL  = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LISTEN = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
  localparam logic [15:0] SAMPLES_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic        entry_valid;
    logic [28:0] frame_id;
    logic [7:0]  frame_pid;
    logic [63:0] frame_payload;
    logic [4:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  scan_phase;
    logic [5:0]  entry_count;
    logic        hit;
    logic        inserted;
    logic        dropped;
    logic        window_closed;
    logic        rd_valid;
    logic [28:0] rd_frame_id;
    logic [7:0]  rd_pid;
    logic [15:0] rd_samples;
    logic [63:0] rd_payload;
  } out_t;

  typedef struct packed {
    logic [28:0] id;
    logic [7:0]  pid;
    logic [15:0] samples;
    logic [63:0] payload;
  } entry_t;

endpackage

>>> src/cict_ram.sv
module cict_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/can_id_census_table.sv
// Census of CAN (id, PID) pairs held in one single-port-write, registered-read table RAM.
// A listening observe word scans the table one entry per cycle, starting at entry 0; with an
// empty table it goes straight to the insert. A hit or insert is written back at the end.
// In-range read words fetch their entry in ST_RDATA before ST_EMIT; one word is in work at a time.
// A result waits in the output register while the next word is accepted.
// Synchronous reset sets the idle phase with an empty table; the RAM is not cleared.
module can_id_census_table_core #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  cict_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cict_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int ENT_W = $bits(cict_pkg::entry_t);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_RDATA = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]       state;
  logic [2:0]       first_state;
  logic [1:0]       phase;
  logic [16:0]      elapsed;
  logic [16:0]      elapsed_next;
  logic [CNT_W-1:0] count;
  logic [15:0]      duration;
  logic [IDX_W-1:0] cmp_idx;
  cict_pkg::in_t    in_q;

  logic             res_hit;
  logic             res_ins;
  logic             res_drop;
  logic             res_closed;
  logic             res_rdv;
  cict_pkg::entry_t res_entry;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  cict_pkg::entry_t rd_entry;
  cict_pkg::entry_t new_entry;
  cict_pkg::entry_t upd_entry;

  logic accept;
  logic match;
  logic last;
  logic room;
  logic rd_in_range;
  logic closing;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign rd_entry  = ram_rdata;
  assign match     = (rd_entry.id == in_q.frame_id) && (rd_entry.pid == in_q.frame_pid);
  assign last      = (CNT_W'(cmp_idx) == (count - CNT_W'(1)));
  assign room      = (count < CNT_W'(TABLE_ENTRIES));
  assign rd_in_range = (CMP_W'(in_data.read_index) < CMP_W'(count));
  assign elapsed_next = (elapsed < cict_pkg::ELAPSED_MAX) ? (elapsed + 17'd1) : elapsed;
  assign closing   = (in_data.mode == cict_pkg::MODE_TICK) && (phase == cict_pkg::PH_LISTEN)
                     && (elapsed_next > {1'b0, duration});

  // Where an accepted word goes next.
  always_comb begin
    first_state = ST_EMIT;
    if (in_data.mode == cict_pkg::MODE_OBSERVE && phase == cict_pkg::PH_LISTEN
        && in_data.entry_valid) begin
      first_state = (count == '0) ? ST_INS : ST_SCAN;
    end else if (in_data.mode == cict_pkg::MODE_READ && rd_in_range) begin
      first_state = ST_RDATA;
    end
  end

  always_comb begin
    new_entry.id      = in_q.frame_id;
    new_entry.pid     = in_q.frame_pid;
    new_entry.samples = 16'd1;
    new_entry.payload = in_q.frame_payload;

    upd_entry.id      = rd_entry.id;
    upd_entry.pid     = rd_entry.pid;
    upd_entry.samples = (rd_entry.samples == cict_pkg::SAMPLES_MAX) ? rd_entry.samples
                                                                    : rd_entry.samples + 16'd1;
    upd_entry.payload = in_q.frame_payload;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(count);
    ram_wdata = new_entry;
    ram_raddr = cmp_idx + IDX_W'(1);
    unique case (state)
      ST_IDLE: begin
        if (in_data.mode == cict_pkg::MODE_READ) begin
          ram_raddr = IDX_W'(in_data.read_index);
        end else begin
          ram_raddr = '0;
        end
      end
      ST_SCAN: begin
        if (match) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx;
          ram_wdata = upd_entry;
        end else if (last && room) begin
          ram_we = 1'b1;
        end
      end
      ST_INS: begin
        ram_we = room;
      end
      default: begin
      end
    endcase
  end

  cict_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= cict_pkg::PH_IDLE;
      elapsed   <= '0;
      count     <= '0;
      duration  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        duration <= cfg_wdata;
      end
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            in_q       <= in_data;
            cmp_idx    <= '0;
            res_hit    <= 1'b0;
            res_ins    <= 1'b0;
            res_drop   <= 1'b0;
            res_closed <= closing;
            res_rdv    <= 1'b0;
            res_entry  <= '0;
            state      <= first_state;
            unique case (in_data.mode)
              cict_pkg::MODE_TICK: begin
                if (phase == cict_pkg::PH_LISTEN) begin
                  elapsed <= elapsed_next;
                  if (closing) begin
                    phase <= cict_pkg::PH_DONE;
                  end
                end
              end
              cict_pkg::MODE_START: begin
                count   <= '0;
                elapsed <= '0;
                phase   <= cict_pkg::PH_LISTEN;
              end
              cict_pkg::MODE_CANCEL: begin
                count   <= '0;
                elapsed <= '0;
                phase   <= cict_pkg::PH_IDLE;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Entry cmp_idx is on the read port now; the next address is already issued.
          if (match) begin
            res_hit <= 1'b1;
            state   <= ST_EMIT;
          end else if (last) begin
            if (room) begin
              count   <= count + CNT_W'(1);
              res_ins <= 1'b1;
            end else begin
              res_drop <= 1'b1;
            end
            state <= ST_EMIT;
          end else begin
            cmp_idx <= cmp_idx + IDX_W'(1);
          end
        end
        ST_INS: begin
          if (room) begin
            count   <= count + CNT_W'(1);
            res_ins <= 1'b1;
          end else begin
            res_drop <= 1'b1;
          end
          state <= ST_EMIT;
        end
        ST_RDATA: begin
          res_rdv   <= 1'b1;
          res_entry <= rd_entry;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.scan_phase    <= phase;
            out_data.entry_count   <= 6'(count);
            out_data.hit           <= res_hit;
            out_data.inserted      <= res_ins;
            out_data.dropped       <= res_drop;
            out_data.window_closed <= res_closed;
            out_data.rd_valid      <= res_rdv;
            out_data.rd_frame_id   <= res_entry.id;
            out_data.rd_pid        <= res_entry.pid;
            out_data.rd_samples    <= res_entry.samples;
            out_data.rd_payload    <= res_entry.payload;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/cict_checker.sv
module cict_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input cict_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input cict_pkg::out_t out_data,
  input logic           cfg_we,
  input logic [15:0]    cfg_wdata
);

  logic unused_inputs;
  assign unused_inputs = ^{in_data, cfg_we, cfg_wdata};

  // A held result word must not change while the far side stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // Only one word is in work, so the input stalls right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in work");

  a_closed_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.window_closed |-> out_data.scan_phase == cict_pkg::PH_DONE)
    else $error("window closed but phase is not done");

  // An inserted, hit or returned entry implies a non-empty table.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.inserted || out_data.rd_valid || out_data.hit)
      |-> out_data.entry_count != 6'd0)
    else $error("entry reported with an empty table");

endmodule

bind can_id_census_table_core cict_checker u_cict_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data),
  .cfg_we   (cfg_we),
  .cfg_wdata(cfg_wdata)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int          TBL_DEPTH   = 32;
  localparam logic [2:0]  MODE_SPARE5 = 3'd5;
  localparam logic [2:0]  MODE_SPARE6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;
  localparam int          SETTLE_CYC  = 40;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  cict_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  cict_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [15:0]    cfg_wdata = '0;

  can_id_census_table_core #(
    .TABLE_ENTRIES(TBL_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Census commands waiting to be sent, and census results still owed by the block.
  cict_pkg::in_t  census_cmds[$];
  cict_pkg::out_t census_replies[$];

  // Shadow of the census state.
  logic [1:0]       census_phase;
  logic [16:0]      census_ms;
  int               census_len;
  cict_pkg::entry_t census_tbl[TBL_DEPTH];
  logic [15:0]      window_ms;

  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  logic        idle_on = 1'b1;
  logic        choke_req = 1'b0;
  logic        choke = 1'b0;
  int          tx_wait = 0;
  int          rx_wait = 0;
  int          errors = 0;

  logic [28:0] pool_id[48];
  logic [7:0]  pool_pid[48];
  int          pool_n = 1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic cict_pkg::out_t census_apply(cict_pkg::in_t w);
    cict_pkg::out_t r;
    int   slot;
    int   i;
    r = '0;
    slot = -1;
    case (w.mode)
      cict_pkg::MODE_OBSERVE: begin
        if (census_phase == cict_pkg::PH_LISTEN && w.entry_valid) begin
          for (i = 0; i < census_len; i++) begin
            if (slot < 0 && census_tbl[i].id == w.frame_id && census_tbl[i].pid == w.frame_pid)
              slot = i;
          end
          if (slot >= 0) begin
            if (census_tbl[slot].samples != cict_pkg::SAMPLES_MAX)
              census_tbl[slot].samples = census_tbl[slot].samples + 16'd1;
            census_tbl[slot].payload = w.frame_payload;
            r.hit = 1'b1;
          end else if (census_len < TBL_DEPTH) begin
            census_tbl[census_len] = '{id: w.frame_id, pid: w.frame_pid, samples: 16'd1,
                                       payload: w.frame_payload};
            census_len++;
            r.inserted = 1'b1;
          end else begin
            r.dropped = 1'b1;
          end
        end
      end
      cict_pkg::MODE_TICK: begin
        if (census_phase == cict_pkg::PH_LISTEN) begin
          if (census_ms != cict_pkg::ELAPSED_MAX) census_ms = census_ms + 17'd1;
          if (census_ms > {1'b0, window_ms}) begin
            census_phase = cict_pkg::PH_DONE;
            r.window_closed = 1'b1;
          end
        end
      end
      cict_pkg::MODE_START: begin
        census_len = 0;
        census_ms = '0;
        census_phase = cict_pkg::PH_LISTEN;
      end
      cict_pkg::MODE_CANCEL: begin
        census_len = 0;
        census_ms = '0;
        census_phase = cict_pkg::PH_IDLE;
      end
      cict_pkg::MODE_READ: begin
        if (int'(w.read_index) < census_len) begin
          r.rd_valid = 1'b1;
          r.rd_frame_id = census_tbl[w.read_index].id;
          r.rd_pid = census_tbl[w.read_index].pid;
          r.rd_samples = census_tbl[w.read_index].samples;
          r.rd_payload = census_tbl[w.read_index].payload;
        end
      end
      default: ;
    endcase
    r.scan_phase = census_phase;
    r.entry_count = census_len[5:0];
    return r;
  endfunction

  task automatic report_bad(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 40)
      $display("ERROR at %0t: %s is %0h, should be %0h", $time, what, got, want);
  endtask

  task automatic check_result(cict_pkg::out_t got, cict_pkg::out_t want);
    if (got.scan_phase !== want.scan_phase)
      report_bad("scan_phase", got.scan_phase, want.scan_phase);
    if (got.entry_count !== want.entry_count)
      report_bad("entry_count", got.entry_count, want.entry_count);
    if (got.hit !== want.hit) report_bad("hit", got.hit, want.hit);
    if (got.inserted !== want.inserted) report_bad("inserted", got.inserted, want.inserted);
    if (got.dropped !== want.dropped) report_bad("dropped", got.dropped, want.dropped);
    if (got.window_closed !== want.window_closed)
      report_bad("window_closed", got.window_closed, want.window_closed);
    if (got.rd_valid !== want.rd_valid) report_bad("rd_valid", got.rd_valid, want.rd_valid);
    if (got.rd_frame_id !== want.rd_frame_id)
      report_bad("rd_frame_id", got.rd_frame_id, want.rd_frame_id);
    if (got.rd_pid !== want.rd_pid) report_bad("rd_pid", got.rd_pid, want.rd_pid);
    if (got.rd_samples !== want.rd_samples)
      report_bad("rd_samples", got.rd_samples, want.rd_samples);
    if (got.rd_payload !== want.rd_payload)
      report_bad("rd_payload", got.rd_payload, want.rd_payload);
  endtask

  // Monitor and predictor: everything is sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      census_phase = cict_pkg::PH_IDLE;
      census_ms = '0;
      census_len = 0;
      window_ms = '0;
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      if (cfg_we) window_ms = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (census_replies.size() == 0) report_bad("unexpected word", out_data[63:0], '0);
        else check_result(out_data, census_replies.pop_front());
      end
      if (in_valid && !in_stall) census_replies.push_back(census_apply(in_data));
      in_took <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
    end
  end

  function automatic int draw_wait();
    if (!idle_on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else if (!in_valid || in_took) begin
      if (in_took) tx_wait = draw_wait();
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (census_cmds.size() != 0) begin
        in_data <= census_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_took) rx_wait = draw_wait();
      if (choke) begin
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One long receiver hold-off, so the block backs up and stalls its input.
  initial begin
    wait (choke_req);
    choke = 1'b1;
    repeat (300) @(posedge clk);
    choke = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic cict_pkg::in_t noise_word(logic [2:0] m);
    cict_pkg::in_t w;
    w.mode = m;
    w.entry_valid = 1'($urandom);
    w.frame_id = 29'($urandom);
    w.frame_pid = 8'($urandom);
    w.frame_payload = {$urandom, $urandom};
    w.read_index = 5'($urandom);
    return w;
  endfunction

  function automatic cict_pkg::in_t observe_word(logic [28:0] id, logic [7:0] pid,
                                                 logic [63:0] pay, logic vld);
    cict_pkg::in_t w;
    w = noise_word(cict_pkg::MODE_OBSERVE);
    w.frame_id = id;
    w.frame_pid = pid;
    w.frame_payload = pay;
    w.entry_valid = vld;
    return w;
  endfunction

  function automatic cict_pkg::in_t read_word(logic [4:0] idx);
    cict_pkg::in_t w;
    w = noise_word(cict_pkg::MODE_READ);
    w.read_index = idx;
    return w;
  endfunction

  // Mostly observes of keys from a small pool so that hits, inserts and drops all occur.
  function automatic cict_pkg::in_t random_word();
    int            pick;
    int            k;
    cict_pkg::in_t w;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, pool_n - 1);
    if (pick < 55) begin
      w = observe_word(pool_id[k], pool_pid[k], {$urandom, $urandom},
                       $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 6) == 0) w.frame_id = 29'($urandom);
    end else if (pick < 67) w = noise_word(cict_pkg::MODE_TICK);
    else if (pick < 85) w = noise_word(cict_pkg::MODE_READ);
    else if (pick < 88) w = noise_word(cict_pkg::MODE_START);
    else if (pick < 90) w = noise_word(cict_pkg::MODE_CANCEL);
    else if (pick < 94) w = noise_word(3'($urandom_range(MODE_SPARE5, MODE_SPARE7)));
    else w = noise_word(cict_pkg::MODE_OBSERVE);
    return w;
  endfunction

  task automatic fill_pool(int n);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      pool_id[i] = 29'($urandom);
      pool_pid[i] = 8'($urandom);
    end
  endtask

  // Waits until every command is sent and answered, then lets the block settle.
  task automatic drain();
    while (census_cmds.size() != 0 || census_replies.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_window(logic [15:0] ms);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ms;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] ms;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words with a two-tick window.
    drain();
    set_window(16'd2);
    census_cmds.push_back(read_word(5'd0));
    census_cmds.push_back(observe_word('1, '1, '1, 1'b1));
    census_cmds.push_back(noise_word(cict_pkg::MODE_TICK));
    census_cmds.push_back(noise_word(cict_pkg::MODE_START));
    census_cmds.push_back(observe_word(29'h0ABCDEF, 8'h11, '1, 1'b0));
    census_cmds.push_back(observe_word('1, '1, '1, 1'b1));
    census_cmds.push_back(observe_word('0, '0, '0, 1'b1));
    census_cmds.push_back(observe_word('1, '1, 64'h0123456789ABCDEF, 1'b1));
    census_cmds.push_back(observe_word('1, '0, 64'hFEDCBA9876543210, 1'b1));
    census_cmds.push_back(read_word(5'd0));
    census_cmds.push_back(read_word(5'd1));
    census_cmds.push_back(read_word(5'd2));
    census_cmds.push_back(read_word(5'd31));
    census_cmds.push_back(noise_word(MODE_SPARE5));
    census_cmds.push_back(noise_word(MODE_SPARE6));
    census_cmds.push_back(noise_word(MODE_SPARE7));
    repeat (3) census_cmds.push_back(noise_word(cict_pkg::MODE_TICK));
    census_cmds.push_back(observe_word(29'h1, 8'h1, '1, 1'b1));
    census_cmds.push_back(read_word(5'd0));
    census_cmds.push_back(noise_word(cict_pkg::MODE_START));
    census_cmds.push_back(observe_word(29'h2, 8'h2, '0, 1'b1));
    census_cmds.push_back(noise_word(cict_pkg::MODE_CANCEL));
    census_cmds.push_back(read_word(5'd0));

    // The receiver chokes while the sender keeps offering words.
    drain();
    set_window(16'd30);
    idle_on = 1'b0;
    fill_pool(24);
    choke_req = 1'b1;
    census_cmds.push_back(noise_word(cict_pkg::MODE_START));
    repeat (80) census_cmds.push_back(random_word());

    for (int ph = 0; ph < 17; ph++) begin
      drain();
      case ($urandom_range(0, 4))
        0: ms = 16'd0;
        1: ms = 16'd1;
        2: ms = 16'($urandom_range(2, 15));
        3: ms = 16'($urandom_range(16, 200));
        default: ms = 16'hFFFF;
      endcase
      set_window(ms);
      idle_on = (ph % 4 != 3);
      fill_pool((ph % 2 == 0) ? $urandom_range(20, 48) : $urandom_range(1, 19));
      census_cmds.push_back(noise_word(cict_pkg::MODE_START));
      repeat (100) census_cmds.push_back(random_word());
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
src/cict_pkg.sv
src/cict_ram.sv
src/can_id_census_table.sv
src/cict_checker.sv
sim/testbench.sv
